>>> src/adsr_se_pkg.sv
// Shared types and constants for the ADSR sine energy update block.
// No dependencies; used by every module in src.
package adsr_se_pkg;

	localparam int unsigned PHASE_BITS_DEF = 16;

	localparam int unsigned TIME_W   = 24;
	localparam int unsigned LEVEL_W  = 17;
	localparam int unsigned PHASE_W  = 16;
	localparam int unsigned CFG_W    = 24;
	localparam int unsigned CFG_IDX_W = 3;

	// Shared multiplier operand widths
	localparam int unsigned MUL_A_W = 33;
	localparam int unsigned MUL_B_W = 24;
	localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

	// Divider: numerator < den * 2^QUO_W always holds here
	localparam int unsigned QUO_W = 17;
	localparam int unsigned NUM_W = TIME_W + QUO_W;

	localparam logic [16:0] ONE_Q16 = 17'd65536;
	localparam logic [16:0] SIN_A   = 17'd102939;
	localparam logic [15:0] SIN_B   = 16'd42154;
	localparam logic [12:0] SIN_C   = 13'd4765;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ATTACK_TIME   = 3'd0,
		REG_DECAY_TIME    = 3'd1,
		REG_SUSTAIN_TIME  = 3'd2,
		REG_SUSTAIN_LEVEL = 3'd3,
		REG_RELEASE_TIME  = 3'd4,
		REG_PHASE_STEP    = 3'd5,
		REG_PHASE_OFFSET  = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		SEG_ATTACK  = 2'd0,
		SEG_DECAY   = 2'd1,
		SEG_SUSTAIN = 2'd2,
		SEG_RELEASE = 2'd3
	} segment_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEG,
		ST_DMUL,
		ST_DIVGO,
		ST_DIV,
		ST_PH,
		ST_X,
		ST_X2,
		ST_C,
		ST_B,
		ST_A,
		ST_SN,
		ST_L1,
		ST_L2,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [31:0]        time_now;
		logic signed [31:0] energy_in;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] energy_out;
		logic [1:0]         segment;
	} out_word_t;

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [TIME_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quo;
	} div_rsp_t;

endpackage

>>> src/adsr_se_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on adsr_se_pkg.
module adsr_se_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  adsr_se_pkg::div_req_t req,
	output adsr_se_pkg::div_rsp_t rsp
);

	localparam int unsigned TW = adsr_se_pkg::TIME_W;
	localparam int unsigned QW = adsr_se_pkg::QUO_W;
	localparam int unsigned CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [TW-1:0] rem_q;
	logic [TW-1:0] den_q;
	logic [QW-1:0] sh_q;   // low numerator bits in, quotient bits out
	logic [TW:0]   trial;
	logic          ge;

	assign trial = {rem_q, sh_q[QW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end else if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			rem_q <= ge ? TW'(trial - {1'b0, den_q}) : trial[TW-1:0];
			sh_q  <= {sh_q[QW-2:0], ge};
		end else if (req.start) begin
			rem_q <= req.num[adsr_se_pkg::NUM_W-1:QW];
			sh_q  <= req.num[QW-1:0];
			den_q <= req.den;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = sh_q;

endmodule

>>> src/adsr_se_mul.sv
// Shared multiplier with a registered product.
// Depends on adsr_se_pkg.
module adsr_se_mul (
	input  logic                                 clk,
	input  logic [adsr_se_pkg::MUL_A_W-1:0]      a,
	input  logic [adsr_se_pkg::MUL_B_W-1:0]      b,
	output logic [adsr_se_pkg::MUL_P_W-1:0]      p
);

	logic [adsr_se_pkg::MUL_P_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= adsr_se_pkg::MUL_P_W'(a) * adsr_se_pkg::MUL_P_W'(b);
	end

	assign p = p_q;

endmodule

>>> src/adsr_sine_energy_update.sv
// A word needs no division in sustain, or in release at or past its end; attack and release
// go through the shift-subtract divider, and decay multiplies before it divides. The
// sequencer steps share one multiplier for the sine polynomial and the energy product.
// The input is not ready while a word is in work; a finished result sits in the output
// register and the next word is taken meanwhile. Configuration writes are always taken.
// Depends on adsr_se_pkg, adsr_se_div and adsr_se_mul.
module adsr_sine_energy_update #(
	parameter int unsigned PHASE_BITS = adsr_se_pkg::PHASE_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  adsr_se_pkg::in_word_t                  in_data,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output adsr_se_pkg::out_word_t                 out_data,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [adsr_se_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [adsr_se_pkg::CFG_W-1:0]          cfg_data
);

	localparam int unsigned TW   = adsr_se_pkg::TIME_W;
	localparam int unsigned AW   = adsr_se_pkg::MUL_A_W;
	localparam int unsigned BW   = adsr_se_pkg::MUL_B_W;
	localparam int unsigned PW   = adsr_se_pkg::MUL_P_W;
	localparam int unsigned DROP = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;
	localparam logic [13:0] XMASK = ~14'((1 << DROP) - 1);

	// configuration registers
	logic [TW-1:0] attack_q, decay_q, sustain_t_q, release_q;
	logic [16:0]   sustain_l_q;
	logic [15:0]   phase_step_q, phase_offset_q;

	adsr_se_pkg::state_t state_q, state_d;

	logic [31:0]        prev_q;
	logic [31:0]        stored_q;
	logic [31:0]        tnow_q;
	logic [31:0]        delta_q;
	logic signed [32:0] level_q;
	logic [32:0]        lmag_q;
	logic               lneg_q;
	logic               sneg_q;
	logic [1:0]         seg_q;
	logic [16:0]        env_q;
	logic [16:0]        x_q;
	logic [16:0]        x2_q;
	logic [16:0]        smag_q;
	logic               out_valid_q;
	adsr_se_pkg::out_word_t out_q;

	logic [AW-1:0] mul_a;
	logic [BW-1:0] mul_b;
	logic [PW-1:0] mul_p;

	adsr_se_pkg::div_req_t div_req;
	adsr_se_pkg::div_rsp_t div_rsp;

	adsr_se_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	adsr_se_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// segment boundaries
	logic [16:0] sus_lvl;
	logic [32:0] b_ad, b_adt;
	logic [32:0] rel_r;
	logic        in_att, in_dec, in_sus, rel_zero;
	logic [TW-1:0] dec_rem, rel_rem;

	assign sus_lvl  = (sustain_l_q > adsr_se_pkg::ONE_Q16) ? adsr_se_pkg::ONE_Q16 : sustain_l_q;
	assign b_ad     = 33'(attack_q) + 33'(decay_q);
	assign b_adt    = b_ad + 33'(sustain_t_q);
	assign in_att   = {1'b0, delta_q} < 33'(attack_q);
	assign in_dec   = {1'b0, delta_q} < b_ad;
	assign in_sus   = {1'b0, delta_q} < b_adt;
	assign rel_r    = {1'b0, delta_q} - b_adt;
	assign rel_zero = (release_q == '0) || (rel_r >= 33'(release_q));
	assign dec_rem  = TW'(b_ad - {1'b0, delta_q});
	assign rel_rem  = TW'(33'(release_q) - rel_r);

	// phase to quarter-wave argument
	logic [15:0] p16;
	logic [16:0] xr;

	assign p16 = mul_p[15:0] + phase_offset_q;
	assign xr  = {1'b0, p16[13:0] & XMASK, 2'b00};

	// final magnitude and saturation
	logic [32:0] mag;
	logic        neg;
	logic [31:0] result;
	logic [16:0] sraw;

	assign sraw = mul_p[32:16];
	assign mag  = mul_p[48:16];
	assign neg  = (lneg_q != sneg_q) && (mag != '0);
	always_comb begin
		if (neg)
			result = (mag >= 33'h0_8000_0000) ? 32'h8000_0000 : 32'(33'd0 - mag);
		else
			result = (mag >= 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
	end

	assign in_ready  = (state_q == adsr_se_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= adsr_se_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d     = state_q;
		mul_a       = '0;
		mul_b       = '0;
		div_req     = '0;
		case (state_q)
			adsr_se_pkg::ST_IDLE: begin
				if (in_valid)
					state_d = adsr_se_pkg::ST_SEG;
			end
			adsr_se_pkg::ST_SEG: begin
				div_req.den = in_att ? attack_q : release_q;
				div_req.num = in_att ? {1'b0, delta_q[TW-1:0], 16'd0} : {1'b0, rel_rem, 16'd0};
				if (in_att) begin
					div_req.start = 1'b1;
					state_d = adsr_se_pkg::ST_DIV;
				end else if (in_dec) begin
					state_d = adsr_se_pkg::ST_DMUL;
				end else if (in_sus || rel_zero) begin
					state_d = adsr_se_pkg::ST_PH;
				end else begin
					div_req.start = 1'b1;
					state_d = adsr_se_pkg::ST_DIV;
				end
			end
			adsr_se_pkg::ST_DMUL: begin
				mul_a   = AW'(adsr_se_pkg::ONE_Q16 - sus_lvl);
				mul_b   = dec_rem;
				state_d = adsr_se_pkg::ST_DIVGO;
			end
			adsr_se_pkg::ST_DIVGO: begin
				div_req.start = 1'b1;
				div_req.num   = mul_p[adsr_se_pkg::NUM_W-1:0];
				div_req.den   = decay_q;
				state_d       = adsr_se_pkg::ST_DIV;
			end
			adsr_se_pkg::ST_DIV: begin
				if (div_rsp.done)
					state_d = adsr_se_pkg::ST_PH;
			end
			adsr_se_pkg::ST_PH: begin
				mul_a   = AW'(phase_step_q);
				mul_b   = BW'(tnow_q[15:0]);
				state_d = adsr_se_pkg::ST_X;
			end
			adsr_se_pkg::ST_X: begin
				state_d = adsr_se_pkg::ST_X2;
			end
			adsr_se_pkg::ST_X2: begin
				mul_a   = AW'(x_q);
				mul_b   = BW'(x_q);
				state_d = adsr_se_pkg::ST_C;
			end
			adsr_se_pkg::ST_C: begin
				mul_a   = AW'(adsr_se_pkg::SIN_C);
				mul_b   = BW'(mul_p[32:16]);
				state_d = adsr_se_pkg::ST_B;
			end
			adsr_se_pkg::ST_B: begin
				mul_a   = AW'(adsr_se_pkg::SIN_B - mul_p[31:16]);
				mul_b   = BW'(x2_q);
				state_d = adsr_se_pkg::ST_A;
			end
			adsr_se_pkg::ST_A: begin
				mul_a   = AW'(adsr_se_pkg::SIN_A - mul_p[32:16]);
				mul_b   = BW'(x_q);
				state_d = adsr_se_pkg::ST_SN;
			end
			adsr_se_pkg::ST_SN: begin
				state_d = adsr_se_pkg::ST_L1;
			end
			adsr_se_pkg::ST_L1: begin
				mul_a   = lmag_q;
				mul_b   = BW'(env_q);
				state_d = adsr_se_pkg::ST_L2;
			end
			adsr_se_pkg::ST_L2: begin
				mul_a   = mul_p[48:16];
				mul_b   = BW'(smag_q);
				state_d = adsr_se_pkg::ST_OUT;
			end
			adsr_se_pkg::ST_OUT: begin
				// times one in Q16 keeps the magnitude while the output is held
				mul_a   = mul_p[48:16];
				mul_b   = BW'(adsr_se_pkg::ONE_Q16);
				if (!out_valid_q || out_ready)
					state_d = adsr_se_pkg::ST_IDLE;
			end
			default: state_d = adsr_se_pkg::ST_IDLE;
		endcase
	end

	// control state and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q       <= TW'(100);
			decay_q        <= TW'(100);
			sustain_t_q    <= TW'(100);
			sustain_l_q    <= 17'd32768;
			release_q      <= TW'(100);
			phase_step_q   <= '0;
			phase_offset_q <= '0;
			prev_q         <= '0;
			stored_q       <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					adsr_se_pkg::REG_ATTACK_TIME:   attack_q       <= cfg_data;
					adsr_se_pkg::REG_DECAY_TIME:    decay_q        <= cfg_data;
					adsr_se_pkg::REG_SUSTAIN_TIME:  sustain_t_q    <= cfg_data;
					adsr_se_pkg::REG_SUSTAIN_LEVEL: sustain_l_q    <= cfg_data[16:0];
					adsr_se_pkg::REG_RELEASE_TIME:  release_q      <= cfg_data;
					adsr_se_pkg::REG_PHASE_STEP:    phase_step_q   <= cfg_data[15:0];
					adsr_se_pkg::REG_PHASE_OFFSET:  phase_offset_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == adsr_se_pkg::ST_IDLE && in_valid)
				prev_q <= in_data.time_now;
			if (state_q == adsr_se_pkg::ST_OUT && (!out_valid_q || out_ready)) begin
				stored_q    <= result;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			adsr_se_pkg::ST_IDLE: begin
				tnow_q  <= in_data.time_now;
				delta_q <= (in_data.time_now >= prev_q) ? in_data.time_now - prev_q : '0;
				level_q <= 33'(signed'(stored_q)) + 33'(in_data.energy_in);
			end
			adsr_se_pkg::ST_SEG: begin
				lneg_q <= level_q[32];
				lmag_q <= level_q[32] ? 33'(-level_q) : 33'(level_q);
				if (in_att)
					seg_q <= adsr_se_pkg::SEG_ATTACK;
				else if (in_dec)
					seg_q <= adsr_se_pkg::SEG_DECAY;
				else if (in_sus)
					seg_q <= adsr_se_pkg::SEG_SUSTAIN;
				else
					seg_q <= adsr_se_pkg::SEG_RELEASE;
				env_q <= (!in_att && !in_dec && in_sus) ? sus_lvl : '0;
			end
			adsr_se_pkg::ST_DIV: begin
				if (div_rsp.done)
					env_q <= (seg_q == adsr_se_pkg::SEG_DECAY) ?
						17'(sus_lvl + div_rsp.quo) : div_rsp.quo;
			end
			adsr_se_pkg::ST_X: begin
				sneg_q <= p16[15];
				x_q    <= p16[14] ? 17'(adsr_se_pkg::ONE_Q16 - xr) : xr;
			end
			adsr_se_pkg::ST_C: begin
				x2_q <= mul_p[32:16];
			end
			adsr_se_pkg::ST_SN: begin
				smag_q <= (sraw > adsr_se_pkg::ONE_Q16) ? adsr_se_pkg::ONE_Q16 : sraw;
			end
			adsr_se_pkg::ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.energy_out <= result;
					out_q.segment    <= seg_q;
				end
			end
			default: ;
		endcase
	end

endmodule

>>> dv/tb.sv
// Self-checking testbench for adsr_sine_energy_update: directed and random words,
// register settings and handshake pressure, checked against an in-bench predictor.
// Depends on src/adsr_se_pkg.sv and the block's RTL.
`timescale 1ns / 100ps

module tb;

	localparam logic [adsr_se_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned RX_HOLD_CYCLES = 400;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	adsr_se_pkg::in_word_t in_data;
	logic out_valid;
	logic out_ready;
	adsr_se_pkg::out_word_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [adsr_se_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [adsr_se_pkg::CFG_W-1:0] cfg_data;

	// predictor copy of registers and state
	logic [23:0] attack_q, decay_q, sustain_q, release_q;
	logic [16:0] sus_level_q;
	logic [15:0] phase_step_q, phase_offset_q;
	logic [31:0] last_time_q, energy_q;

	adsr_se_pkg::out_word_t pending_words[$];
	int unsigned tx_idle_pct, rx_idle_pct;
	int unsigned rx_hold;
	int unsigned hold_reqs = 0;
	int unsigned hold_seen;
	int unsigned errors = 0;
	int unsigned words_checked = 0;
	int unsigned cycles = 0;
	int unsigned words_sent, cfg_writes;
	logic [31:0] time_cursor;

	adsr_sine_energy_update DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [63:0] quarter_sine(logic [63:0] x);
		logic [63:0] x2, t;
		x2 = (x * x) >> 16;
		t = (64'(adsr_se_pkg::SIN_C) * x2) >> 16;
		t = 64'(adsr_se_pkg::SIN_B) - t;
		t = (t * x2) >> 16;
		t = 64'(adsr_se_pkg::SIN_A) - t;
		t = (t * x) >> 16;
		return (t > 64'(adsr_se_pkg::ONE_Q16)) ? 64'(adsr_se_pkg::ONE_Q16) : t;
	endfunction

	function automatic void set_register(logic [adsr_se_pkg::CFG_IDX_W-1:0] idx,
		logic [adsr_se_pkg::CFG_W-1:0] val);
		case (idx)
			adsr_se_pkg::REG_ATTACK_TIME:   attack_q = val;
			adsr_se_pkg::REG_DECAY_TIME:    decay_q = val;
			adsr_se_pkg::REG_SUSTAIN_TIME:  sustain_q = val;
			adsr_se_pkg::REG_SUSTAIN_LEVEL: sus_level_q = val[16:0];
			adsr_se_pkg::REG_RELEASE_TIME:  release_q = val;
			adsr_se_pkg::REG_PHASE_STEP:    phase_step_q = val[15:0];
			adsr_se_pkg::REG_PHASE_OFFSET:  phase_offset_q = val[15:0];
			default: ;
		endcase
	endfunction

	// energy update for one word; advances predictor state
	function automatic adsr_se_pkg::out_word_t energy_update(logic [31:0] t_now,
		logic [31:0] e_in);
		adsr_se_pkg::out_word_t r;
		logic signed [63:0] level;
		logic [63:0] delta, a, d, s, rt, sl, env, lmag, smag, mag, p, x, tt;
		logic [1:0] quad;
		adsr_se_pkg::segment_t seg;
		logic lneg, sneg, neg;
		level = 64'(signed'(energy_q)) + 64'(signed'(e_in));
		delta = (t_now >= last_time_q) ? 64'(t_now - last_time_q) : 64'd0;
		a = attack_q; d = decay_q; s = sustain_q; rt = release_q;
		sl = (sus_level_q > adsr_se_pkg::ONE_Q16) ? 64'(adsr_se_pkg::ONE_Q16) :
			64'(sus_level_q);
		last_time_q = t_now;
		if (delta < a) begin
			seg = adsr_se_pkg::SEG_ATTACK;
			env = (delta << 16) / a;
		end else if (delta < a + d) begin
			seg = adsr_se_pkg::SEG_DECAY;
			tt = delta - a;
			env = sl + ((d - tt) * (64'(adsr_se_pkg::ONE_Q16) - sl)) / d;
		end else if (delta < a + d + s) begin
			seg = adsr_se_pkg::SEG_SUSTAIN;
			env = sl;
		end else begin
			seg = adsr_se_pkg::SEG_RELEASE;
			tt = delta - a - d - s;
			env = (rt == 0 || tt >= rt) ? 64'd0 : ((rt - tt) << 16) / rt;
		end
		p = (64'(phase_step_q) * 64'(t_now) + 64'(phase_offset_q)) & 64'hFFFF;
		quad = p[15:14];
		x = {p[13:0], 2'b00};
		if (quad[0])
			x = 64'(adsr_se_pkg::ONE_Q16) - x;
		smag = quarter_sine(x);
		sneg = quad[1];
		lneg = level < 0;
		lmag = lneg ? 64'(-level) : 64'(level);
		mag = (lmag * env) >> 16;
		mag = (mag * smag) >> 16;
		neg = (lneg != sneg) && mag != 0;
		if (neg)
			r.energy_out = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(0) - mag[31:0];
		else
			r.energy_out = (mag >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
		r.segment = seg;
		energy_q = r.energy_out;
		return r;
	endfunction

	// receive side: random stalls, or a long hold-off when asked
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_reqs) begin
			hold_seen <= hold_reqs;
			rx_hold <= RX_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		adsr_se_pkg::out_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_words.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected word: energy %h segment %0d",
						out_data.energy_out, out_data.segment);
			end else begin
				want = pending_words.pop_front();
				words_checked++;
				if (out_data.energy_out !== want.energy_out ||
					out_data.segment !== want.segment) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: energy exp %h got %h, segment exp %0d got %0d",
							want.energy_out, out_data.energy_out, want.segment,
							out_data.segment);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycles,
				pending_words.size());
			$display("[adsr_sine_energy_update] ERROR");
			$finish;
		end
	end

	task automatic send_word(logic [31:0] t_now, logic [31:0] e_in);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < tx_idle_pct && gap < 8)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{time_now: t_now, energy_in: e_in};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_words.push_back(energy_update(t_now, e_in));
		words_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [adsr_se_pkg::CFG_IDX_W-1:0] idx,
		logic [adsr_se_pkg::CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		set_register(idx, val);
		cfg_writes++;
	endtask

	task automatic write_envelope(logic [23:0] a, logic [23:0] d, logic [23:0] s,
		logic [23:0] lvl, logic [23:0] r);
		write_reg(adsr_se_pkg::REG_ATTACK_TIME, a);
		write_reg(adsr_se_pkg::REG_DECAY_TIME, d);
		write_reg(adsr_se_pkg::REG_SUSTAIN_TIME, s);
		write_reg(adsr_se_pkg::REG_SUSTAIN_LEVEL, lvl);
		write_reg(adsr_se_pkg::REG_RELEASE_TIME, r);
	endtask

	// each segment, time extremes, going backwards, energy extremes, all quadrants
	task automatic test_directed();
		write_reg(adsr_se_pkg::REG_PHASE_STEP, 24'd4096);
		write_reg(adsr_se_pkg::REG_PHASE_OFFSET, 24'd16384);
		send_word(32'd0, 32'h0001_0000);
		send_word(32'd50, 32'h7FFF_FFFF);
		send_word(32'd150, 32'h8000_0000);
		send_word(32'd270, 32'h0010_0000);
		send_word(32'd430, 32'hFFFF_FFFF);
		send_word(32'd560, 32'h0100_0000);
		send_word(32'd700, 32'h0000_0000);
		send_word(32'd650, 32'h4000_0000);
		send_word(32'hFFFF_FFFF, 32'hC000_0000);
		send_word(32'd3, 32'h7FFF_FFFF);
		send_word(32'd8, 32'h8000_0001);
		send_word(32'd13, 32'h2345_6789);
		drain();
		// zero attack and decay, zero release, sustain level above one
		write_envelope(24'd0, 24'd0, 24'd20, 24'h01FFFF, 24'd0);
		write_reg(adsr_se_pkg::REG_PHASE_STEP, 24'hFFFFFF);
		write_reg(adsr_se_pkg::REG_PHASE_OFFSET, 24'hABFFFF);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		send_word(32'd13, 32'h7FFF_FFFF);
		send_word(32'd30, 32'h8000_0000);
		send_word(32'd60, 32'h0123_4567);
		send_word(32'd62, 32'h7FFF_FFFF);
		drain();
		write_envelope(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h010000, 24'hFFFFFF);
		send_word(32'hFFFF_0000, 32'h7FFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'h8000_0000);
		send_word(32'd0, 32'h5555_5555);
		drain();
		write_envelope(24'd1, 24'd1, 24'd1, 24'd0, 24'd1);
		send_word(32'd0, 32'h7FFF_FFFF);
		send_word(32'd1, 32'h7FFF_FFFF);
		send_word(32'd3, 32'h7FFF_FFFF);
		send_word(32'd6, 32'h7FFF_FFFF);
		drain();
		time_cursor = 32'd6;
	endtask

	task automatic random_settings();
		int unsigned sel;
		sel = $urandom_range(9);
		write_envelope(
			(sel == 0) ? 24'd0 : 24'($urandom_range(1, 200)),
			(sel == 1) ? 24'd0 : 24'($urandom_range(1, 200)),
			(sel == 2) ? 24'd0 : 24'($urandom_range(0, 200)),
			(sel < 5) ? 24'($urandom) : 24'($urandom_range(0, 65536)),
			(sel == 3) ? 24'd0 : (sel == 4) ? 24'hFFFFFF : 24'($urandom_range(1, 300)));
		write_reg(adsr_se_pkg::REG_PHASE_STEP, 24'($urandom));
		write_reg(adsr_se_pkg::REG_PHASE_OFFSET, 24'($urandom));
	endtask

	// mostly forward time steps spanning all segments, with jumps and reversals
	task automatic test_random(int unsigned count, int unsigned tx_pct, int unsigned rx_pct);
		logic [31:0] e_in;
		int unsigned k;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int unsigned n = 0; n < count; n++) begin
			if (n % 70 == 0) begin
				drain();
				random_settings();
			end
			k = $urandom_range(99);
			if (k < 5)
				time_cursor = $urandom;
			else if (k < 10)
				time_cursor = time_cursor - $urandom_range(1, 500);
			else
				time_cursor = time_cursor + $urandom_range(0, 900);
			k = $urandom_range(3);
			e_in = $urandom;
			if (k == 0)
				e_in = 32'(signed'(e_in) >>> $urandom_range(0, 31));
			send_word(time_cursor, e_in);
		end
		drain();
	endtask

	// output held off while words keep coming; then a send pause until all results are in
	task automatic test_backpressure();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_reqs++;
		for (int n = 0; n < 12; n++) begin
			time_cursor = time_cursor + $urandom_range(0, 400);
			send_word(time_cursor, $urandom);
		end
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		for (int n = 0; n < 12; n++) begin
			time_cursor = time_cursor + $urandom_range(0, 400);
			send_word(time_cursor, $urandom);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		words_sent = 0;
		cfg_writes = 0;
		attack_q = 24'd100; decay_q = 24'd100; sustain_q = 24'd100;
		sus_level_q = 17'd32768; release_q = 24'd100;
		phase_step_q = '0; phase_offset_q = '0;
		last_time_q = '0; energy_q = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(350, 31, 59);
		test_random(350, 59, 31);
		test_backpressure();
		test_random(350, 0, 0);

		$display("covered %0d words and %0d register writes, %0d results checked",
			words_sent, cfg_writes, words_checked);
		$display("all envelope segments, sine quadrants, saturation and stall patterns run");
		if (errors == 0 && pending_words.size() == 0) begin
			$display("[adsr_sine_energy_update] OK");
		end else begin
			$display("%0d mismatches, %0d words outstanding", errors, pending_words.size());
			$display("[adsr_sine_energy_update] ERROR");
		end
		$finish;
	end

endmodule
